// ===== rtl/cgrs_pkg.sv =====
package cgrs_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] role_type;
   typedef logic [2:0] phase_type;

   localparam phase_type PH_FREE    = 3'd0;
   localparam phase_type PH_NAME    = 3'd1;
   localparam phase_type PH_VALUE   = 3'd2;
   localparam phase_type PH_COMMENT = 3'd3;
   localparam phase_type PH_WIN     = 3'd4;
   localparam phase_type PH_DRAW    = 3'd5;

   localparam role_type ROLE_OTHER     = 4'd0;
   localparam role_type ROLE_TAG_OPEN  = 4'd1;
   localparam role_type ROLE_NAME_CHAR = 4'd2;
   localparam role_type ROLE_NAME_END  = 4'd3;
   localparam role_type ROLE_VALUE     = 4'd4;
   localparam role_type ROLE_TAG_CLOSE = 4'd5;
   localparam role_type ROLE_COM_OPEN  = 4'd6;
   localparam role_type ROLE_COM_CLOSE = 4'd7;
   localparam role_type ROLE_GAME_END  = 4'd8;

   localparam byte_type CH_TAG_OPEN  = 8'h5B;
   localparam byte_type CH_TAG_CLOSE = 8'h5D;
   localparam byte_type CH_COM_OPEN  = 8'h7B;
   localparam byte_type CH_COM_CLOSE = 8'h7D;
   localparam byte_type CH_DASH      = 8'h2D;
   localparam byte_type CH_CAP_O     = 8'h4F;
   localparam byte_type CH_TWO       = 8'h32;
   localparam byte_type CH_STAR      = 8'h2A;
   localparam byte_type CH_LOWER_E   = 8'h65;
   localparam byte_type CH_LOWER_C   = 8'h63;
   localparam byte_type CH_SPACE     = 8'h20;
   localparam byte_type CH_QUOTE     = 8'h22;

   typedef struct packed {
      phase_type phase;
      byte_type  prev_char;
      logic      evals_flag;
      logic      clocks_flag;
   } parse_state_type;

   typedef struct packed {
      byte_type echo_byte;
      role_type role;
      logic     evals_seen;
      logic     clocks_seen;
   } result_type;

   localparam parse_state_type STATE_RESET = '{
      phase:       PH_FREE,
      prev_char:   8'h00,
      evals_flag:  1'b0,
      clocks_flag: 1'b0
   };

endpackage

// ===== rtl/cgrs_ifs.sv =====
interface cgrs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface cgrs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] echo_byte;
   logic [3:0] role;
   logic       evals_seen;
   logic       clocks_seen;

   modport source (output valid, output echo_byte, output role, output evals_seen,
                   output clocks_seen, input ready);
   modport sink (input valid, input echo_byte, input role, input evals_seen,
                 input clocks_seen, output ready);
endinterface

// ===== rtl/chess_game_record_splitter.sv =====
// Splits the text of a chess game record into tagged bytes, one word per byte.
// The req_ch channel carries one raw character per word in in_byte.
// The rsp_ch channel returns exactly one word per input word: the character
// in echo_byte, its role (tag open, name character, name end, value character,
// tag close, comment open, comment close, game end or other) and the
// evaluation and clock flags of the current game, including this byte.
// A word accepted on req_ch is offered on rsp_ch from the next cycle on,
// held in a single result register. Throughput is one word per cycle while
// rsp_ch takes its words; the parse state updates in the same cycle a word
// is accepted, so consecutive bytes never wait on each other.
// When the receiver stalls, the result register holds its word and req_ch
// stays ready only while that register is free or being emptied.
// Reset is synchronous and active high; it empties the result register and
// returns the parser to free text with the flags and previous byte cleared.
// A game end clears the same parse state after its word is produced.
module chess_game_record_splitter (
   input  logic       clock,
   input  logic       reset,
   cgrs_req_if.sink   req_ch,
   cgrs_rsp_if.source rsp_ch
);
   import cgrs_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type next_state;
   result_type      result;
   logic            can_load;
   logic            accept;

   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid && can_load;

   cgrs_classifier u_classifier (
      .state      (state_ff),
      .in_byte    (req_ch.in_byte),
      .next_state (next_state),
      .result     (result)
   );

   cgrs_result_stage u_result_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .result   (result),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

   assign state_in = accept ? next_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_game_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && result.role == ROLE_GAME_END |=> state_ff == STATE_RESET)
      else $error("parse state not cleared after game end");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase <= PH_DRAW)
      else $error("parse phase left its legal range");

   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      accept && result.role != ROLE_GAME_END && state_ff.evals_flag
      |=> state_ff.evals_flag)
      else $error("evaluation flag dropped within a game");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_ch.valid |-> req_ch.ready)
      else $error("input stalled with an empty result register");
`endif

endmodule

// ===== rtl/cgrs_classifier.sv =====
module cgrs_classifier (
   input  cgrs_pkg::parse_state_type state,
   input  cgrs_pkg::byte_type        in_byte,
   output cgrs_pkg::parse_state_type next_state,
   output cgrs_pkg::result_type      result
);
   import cgrs_pkg::*;

   role_type        role;
   logic            done;
   parse_state_type upd;

   always_comb begin
      upd           = state;
      upd.prev_char = in_byte;
      role          = ROLE_OTHER;
      done          = 1'b0;
      case (state.phase)
         PH_FREE: begin
            if (in_byte == CH_TAG_OPEN) begin
               upd.phase = PH_NAME;
               role      = ROLE_TAG_OPEN;
            end else if (in_byte == CH_COM_OPEN) begin
               upd.phase = PH_COMMENT;
               role      = ROLE_COM_OPEN;
            end else if (in_byte == CH_DASH && state.prev_char != CH_CAP_O) begin
               upd.phase = (state.prev_char == CH_TWO) ? PH_DRAW : PH_WIN;
            end else if (in_byte == CH_STAR) begin
               done = 1'b1;
            end
         end
         PH_NAME: begin
            if (in_byte == CH_SPACE) begin
               upd.phase = PH_VALUE;
               role      = ROLE_NAME_END;
            end else begin
               role = ROLE_NAME_CHAR;
            end
         end
         PH_VALUE: begin
            if (in_byte == CH_TAG_CLOSE) begin
               upd.phase = PH_FREE;
               role      = ROLE_TAG_CLOSE;
            end else if (in_byte != CH_QUOTE) begin
               role = ROLE_VALUE;
            end
         end
         PH_COMMENT: begin
            if (in_byte == CH_LOWER_E) begin
               upd.evals_flag = 1'b1;
            end else if (in_byte == CH_LOWER_C) begin
               upd.clocks_flag = 1'b1;
            end else if (in_byte == CH_COM_CLOSE) begin
               upd.phase = PH_FREE;
               role      = ROLE_COM_CLOSE;
            end
         end
         PH_WIN: begin
            done = 1'b1;
         end
         PH_DRAW: begin
            done = (in_byte == CH_TWO);
         end
         default: begin
         end
      endcase

      result.echo_byte   = in_byte;
      result.role        = done ? ROLE_GAME_END : role;
      result.evals_seen  = upd.evals_flag;
      result.clocks_seen = upd.clocks_flag;
      next_state         = done ? STATE_RESET : upd;
   end

endmodule

// ===== rtl/cgrs_result_stage.sv =====
module cgrs_result_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  cgrs_pkg::result_type result,
   output logic                 can_load,
   cgrs_rsp_if.source           rsp_ch
);
   import cgrs_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign can_load = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.echo_byte   = data_ff.echo_byte;
   assign rsp_ch.role        = data_ff.role;
   assign rsp_ch.evals_seen  = data_ff.evals_seen;
   assign rsp_ch.clocks_seen = data_ff.clocks_seen;

endmodule
